### src/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Each macro builds one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LVRF_ASSERT_IMPLY(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LVRF_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/lvrf_pkg.sv
// Package for the layer velocity ramp fill block: widths, register map and
// saturation helper. No dependencies.
`timescale 1ns / 1ps

package lvrf_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // Register map, word index taken from paddr[4:2]
  localparam logic [2:0] REG_DEPTH_ORIGIN  = 3'd0;
  localparam logic [2:0] REG_DEPTH_STEP    = 3'd1;
  localparam logic [2:0] REG_NULL_DEPTH    = 3'd2;
  localparam logic [2:0] REG_SAMPLES       = 3'd3;
  localparam logic [2:0] REG_HAS_BOTTOM    = 3'd4;
  localparam logic [2:0] REG_INIT_MINIMUM  = 3'd5;
  localparam logic [2:0] REG_INIT_MAXIMUM  = 3'd6;

  // Divider: 35-bit dividend magnitude, 33-bit divisor, one quotient bit a cycle
  localparam int DIV_NUM_W = 35;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_STEPS = DIV_NUM_W;
  // Multiplier: 32 x 32 magnitudes, one partial product a cycle
  localparam int MUL_STEPS = 32;
  localparam int CNT_W     = 6;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat_to_32(input logic signed [63:0] v);
    logic hi_same;
    hi_same = (v[63:31] == {33{1'b0}}) || (v[63:31] == {33{1'b1}});
    if (hi_same) begin
      return v[31:0];
    end else if (v[63]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

### src/layer_velocity_ramp_fill_top.sv
// Layer velocity ramp fill: per-column layer indexing, ramp gradient and fill.
// Depends on lvrf_pkg; one shared 64-bit adder serves divide, multiply and ramp.
`timescale 1ns / 1ps

// A trace's first sample runs up to three restoring divisions (top index, bottom
// index, gradient) and a shift-add multiply on the shared adder; later samples
// of a trace go straight to the finish state. A new sample is taken only once
// the current one has been written to the output register.
// Reset (synchronous): registers to defaults, sample index and layer state
// cleared, tracked minimum and maximum set to the initial registers' reset values.
module layer_velocity_ramp_fill_top
  import lvrf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       sample_value,
  input  logic signed [31:0]       top_depth,
  input  logic signed [31:0]       bottom_depth,
  input  logic signed [31:0]       top_velocity,
  input  logic signed [31:0]       bottom_velocity,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       result_value,
  output logic                     trace_end,
  output logic signed [31:0]       running_minimum,
  output logic signed [31:0]       running_maximum,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_TOP, S_BOT, S_GRAD, S_DIV, S_DIV_DONE, S_MSET, S_MUL, S_ACC, S_FINISH
  } state_t;

  typedef enum logic [1:0] {TAG_TOP, TAG_BOT, TAG_GRAD} div_tag_t;

  state_t state;

  // configuration registers
  logic signed [31:0] depth_origin;
  logic [30:0]        depth_step;
  logic signed [31:0] null_depth;
  logic [15:0]        samples_per_trace;
  logic               has_bottom;
  logic signed [31:0] initial_minimum;
  logic signed [31:0] initial_maximum;

  // column and trace state
  logic [15:0]        sample_index;
  logic signed [31:0] top_index;
  logic signed [31:0] bottom_index;
  logic signed [31:0] ramp_gradient;
  logic signed [63:0] ramp_acc;
  logic signed [31:0] minimum_seen;
  logic signed [31:0] maximum_seen;

  // latched input item
  logic signed [31:0] smp;
  logic signed [31:0] top_d;
  logic signed [31:0] bot_d;
  logic signed [31:0] top_v;
  logic signed [31:0] bot_v;

  // divider and multiplier registers
  logic [DIV_NUM_W-1:0] div_q;
  logic [DIV_DEN_W-1:0] div_rem;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_neg;
  div_tag_t             div_tag;
  logic [CNT_W-1:0]     step_cnt;
  logic [63:0]          mul_prod;
  logic [63:0]          mul_mcand;
  logic [31:0]          mul_mplier;
  logic                 mul_neg;

  // shared adder
  logic [63:0] alu_a;
  logic [63:0] alu_b;
  logic        alu_sub;
  logic [63:0] alu_sum;

  logic                 cfg_write;
  logic [2:0]           cfg_idx;
  logic [16:0]          trace_len;
  logic [30:0]          step_eff;
  logic signed [31:0]   idx_depth;
  logic signed [32:0]   depth_diff;
  logic signed [34:0]   idx_num;
  logic [DIV_NUM_W-1:0] idx_mag;
  logic [DIV_DEN_W-1:0] idx_den;
  logic signed [32:0]   span;
  logic signed [32:0]   vel_diff;
  logic [DIV_NUM_W-1:0] vel_mag;
  logic [DIV_DEN_W:0]   rem_shift;
  logic signed [35:0]   quot_signed;
  logic signed [31:0]   quot_sat;
  logic [31:0]          top_mag;
  logic [31:0]          grad_mag;
  logic signed [32:0]   idx_cmp;
  logic                 in_span;
  logic signed [31:0]   value;
  logic                 last;
  logic                 out_free;
  logic                 in_xfer;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign trace_len = (samples_per_trace == 16'd0) ? 17'h1_0000 : {1'b0, samples_per_trace};
  assign step_eff  = (depth_step == 31'd0) ? 31'd1 : depth_step;

  // index = (2*(depth - origin) + step) / (2*step)
  assign idx_depth  = (state == S_BOT) ? bot_d : top_d;
  assign depth_diff = {idx_depth[31], idx_depth} - {depth_origin[31], depth_origin};
  assign idx_num    = {depth_diff[32], depth_diff, 1'b0} + {4'b0, step_eff};
  assign idx_mag    = idx_num[34] ? DIV_NUM_W'(-idx_num) : DIV_NUM_W'(idx_num);
  assign idx_den    = {1'b0, step_eff, 1'b0};

  assign span     = {bottom_index[31], bottom_index} - {top_index[31], top_index};
  assign vel_diff = {bot_v[31], bot_v} - {top_v[31], top_v};
  assign vel_mag  = vel_diff[32] ? {2'b0, 33'(-vel_diff)} : {2'b0, 33'(vel_diff)};

  assign rem_shift   = {div_rem, div_q[DIV_NUM_W-1]};
  assign quot_signed = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign quot_sat    = sat_to_32(64'(quot_signed));

  assign top_mag  = top_index[31] ? 32'(-top_index) : 32'(top_index);
  assign grad_mag = ramp_gradient[31] ? 32'(-ramp_gradient) : 32'(ramp_gradient);

  assign idx_cmp = $signed({17'b0, sample_index});
  assign in_span = (idx_cmp >= $signed({top_index[31], top_index}))
                && (idx_cmp <  $signed({bottom_index[31], bottom_index}));
  assign value   = in_span ? sat_to_32(ramp_acc) : smp;
  assign last    = ({1'b0, sample_index} >= (trace_len - 17'd1));

  always_comb begin
    alu_a   = ramp_acc;
    alu_b   = 64'(ramp_gradient);
    alu_sub = 1'b0;
    case (state)
      S_DIV: begin
        alu_a   = {{(64-DIV_DEN_W-1){1'b0}}, rem_shift};
        alu_b   = {{(64-DIV_DEN_W){1'b0}}, div_den};
        alu_sub = 1'b1;
      end
      S_MUL: begin
        alu_a = mul_prod;
        alu_b = mul_mplier[0] ? mul_mcand : 64'd0;
      end
      S_ACC: begin
        // ramp at index 0: top_velocity - top_index * gradient
        alu_a   = 64'(top_v);
        alu_b   = mul_prod;
        alu_sub = !mul_neg;
      end
      default: begin
        alu_a   = ramp_acc;
        alu_b   = 64'(ramp_gradient);
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {63'b0, alu_sub};

  always_comb begin
    case (cfg_idx)
      REG_DEPTH_ORIGIN: prdata = depth_origin;
      REG_DEPTH_STEP:   prdata = {1'b0, depth_step};
      REG_NULL_DEPTH:   prdata = null_depth;
      REG_SAMPLES:      prdata = {16'b0, samples_per_trace};
      REG_HAS_BOTTOM:   prdata = {31'b0, has_bottom};
      REG_INIT_MINIMUM: prdata = initial_minimum;
      REG_INIT_MAXIMUM: prdata = initial_maximum;
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      depth_origin      <= 32'sd0;
      depth_step        <= 31'd65536;
      null_depth        <= SAT_MAX;
      samples_per_trace <= 16'd1024;
      has_bottom        <= 1'b0;
      initial_minimum   <= SAT_MAX;
      initial_maximum   <= SAT_MIN;
      sample_index      <= 16'd0;
      top_index         <= 32'sd0;
      bottom_index      <= 32'sd0;
      ramp_gradient     <= 32'sd0;
      ramp_acc          <= 64'sd0;
      minimum_seen      <= SAT_MAX;
      maximum_seen      <= SAT_MIN;
      out_valid         <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            smp   <= sample_value;
            top_d <= top_depth;
            bot_d <= bottom_depth;
            top_v <= top_velocity;
            bot_v <= bottom_velocity;
            state <= (sample_index == 16'd0) ? S_TOP : S_FINISH;
          end
        end
        S_TOP: begin
          if (top_d == null_depth) begin
            top_index <= 32'(trace_len);
            state     <= S_BOT;
          end else begin
            div_q    <= idx_mag;
            div_rem  <= '0;
            div_den  <= idx_den;
            div_neg  <= idx_num[34];
            div_tag  <= TAG_TOP;
            step_cnt <= '0;
            state    <= S_DIV;
          end
        end
        S_BOT: begin
          if (!has_bottom) begin
            bottom_index <= 32'(trace_len);
            state        <= S_GRAD;
          end else if (bot_d == null_depth) begin
            bottom_index <= 32'sd0;
            state        <= S_GRAD;
          end else begin
            div_q    <= idx_mag;
            div_rem  <= '0;
            div_den  <= idx_den;
            div_neg  <= idx_num[34];
            div_tag  <= TAG_BOT;
            step_cnt <= '0;
            state    <= S_DIV;
          end
        end
        S_GRAD: begin
          if (span > 33'sd0) begin
            div_q    <= vel_mag;
            div_rem  <= '0;
            div_den  <= DIV_DEN_W'(span);
            div_neg  <= vel_diff[32];
            div_tag  <= TAG_GRAD;
            step_cnt <= '0;
            state    <= S_DIV;
          end else begin
            ramp_gradient <= 32'sd0;
            state         <= S_MSET;
          end
        end
        S_DIV: begin
          // restoring step: keep the difference when it does not go negative
          if (!alu_sum[63]) begin
            div_rem <= alu_sum[DIV_DEN_W-1:0];
          end else begin
            div_rem <= rem_shift[DIV_DEN_W-1:0];
          end
          div_q    <= {div_q[DIV_NUM_W-2:0], !alu_sum[63]};
          step_cnt <= step_cnt + CNT_W'(1);
          if (step_cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_DIV_DONE;
          end
        end
        S_DIV_DONE: begin
          case (div_tag)
            TAG_TOP: begin
              top_index <= quot_sat;
              state     <= S_BOT;
            end
            TAG_BOT: begin
              bottom_index <= quot_sat;
              state        <= S_GRAD;
            end
            default: begin
              ramp_gradient <= quot_sat;
              state         <= S_MSET;
            end
          endcase
        end
        S_MSET: begin
          mul_prod   <= 64'd0;
          mul_mcand  <= {32'd0, top_mag};
          mul_mplier <= grad_mag;
          mul_neg    <= top_index[31] ^ ramp_gradient[31];
          step_cnt   <= '0;
          state      <= S_MUL;
        end
        S_MUL: begin
          mul_prod   <= alu_sum;
          mul_mcand  <= {mul_mcand[62:0], 1'b0};
          mul_mplier <= {1'b0, mul_mplier[31:1]};
          step_cnt   <= step_cnt + CNT_W'(1);
          if (step_cnt == CNT_W'(MUL_STEPS - 1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          ramp_acc <= alu_sum;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid       <= 1'b1;
            result_value    <= value;
            trace_end       <= last;
            running_minimum <= (value < minimum_seen) ? value : minimum_seen;
            running_maximum <= (value > maximum_seen) ? value : maximum_seen;
            if (value < minimum_seen) begin
              minimum_seen <= value;
            end
            if (value > maximum_seen) begin
              maximum_seen <= value;
            end
            ramp_acc     <= alu_sum;
            sample_index <= last ? 16'd0 : sample_index + 16'd1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_write) begin
        case (cfg_idx)
          REG_DEPTH_ORIGIN: depth_origin      <= pwdata;
          REG_DEPTH_STEP:   depth_step        <= pwdata[30:0];
          REG_NULL_DEPTH:   null_depth        <= pwdata;
          REG_SAMPLES:      samples_per_trace <= pwdata[15:0];
          REG_HAS_BOTTOM:   has_bottom        <= pwdata[0];
          REG_INIT_MINIMUM: begin
            initial_minimum <= pwdata;
            minimum_seen    <= pwdata;
          end
          REG_INIT_MAXIMUM: begin
            initial_maximum <= pwdata;
            maximum_seen    <= pwdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### src/lvrf_checker.sv
// Port-level checker for the layer velocity ramp fill top level, with its bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lvrf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [31:0] result_value,
  input logic signed [31:0] running_minimum,
  input logic signed [31:0] running_maximum
);

  // a stalled result holds its value
  `LVRF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(result_value))

  // every result lies within the extremes reported with it
  `LVRF_ASSERT_IMPLY(a_result_bounded, clk, rst, out_valid, (result_value >= running_minimum) && (result_value <= running_maximum))

  // a transfer in starts work, so the block is busy next cycle
  `LVRF_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)

  // the block comes out of reset ready for input
  `LVRF_ASSERT_IMPLY(a_ready_after_reset, clk, rst, $fell(rst), !in_stall)

endmodule

bind layer_velocity_ramp_fill_top lvrf_checker u_lvrf_checker (.*);
